// ===== sv/gradient_threshold_sharpen_assert.svh =====
// Assertion macros for the gradient sharpener.
`ifndef GRADIENT_THRESHOLD_SHARPEN_ASSERT_SVH
`define GRADIENT_THRESHOLD_SHARPEN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gts_pkg.sv =====
package gts_pkg;

  localparam int CFG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [10:0] WIDTH_RST     = 11'd640;
  localparam logic [10:0] HEIGHT_RST    = 11'd480;
  localparam logic [8:0]  THRESHOLD_RST = 9'd40;
  localparam logic [7:0]  BOOST_RST     = 8'd100;
  localparam logic [7:0]  CHAN_MAX      = 8'd255;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2,
    CFG_BOOST_OFFSET   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One pixel of the previous row, waiting to be sharpened.
  typedef struct packed {
    pix_t above;
    pix_t right;
    pix_t below;
    logic last_col;
    logic frame_last;
  } s1_t;

  // |c - right| + |c - below|, boosted and saturated when above threshold.
  function automatic logic [7:0] sharpen_chan(logic [7:0] c, logic [7:0] right,
                                              logic [7:0] below, logic [8:0] thr,
                                              logic [7:0] boost);
    logic [7:0] d_r;
    logic [7:0] d_b;
    logic [8:0] grad;
    logic [9:0] sum;
    d_r  = (c > right) ? c - right : right - c;
    d_b  = (c > below) ? c - below : below - c;
    grad = {1'b0, d_r} + {1'b0, d_b};
    sum  = {1'b0, grad} + {2'b00, boost};
    if (grad > thr) begin
      sharpen_chan = (sum > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum[7:0];
    end else begin
      sharpen_chan = c;
    end
  endfunction

endpackage

// ===== sv/gradient_threshold_sharpen.sv =====
// Streaming RGB888 edge sharpener. Pixels enter in raster order, one per clock
// when both sides keep up. A single line buffer (MaxWidth x 24 bit, one write
// and two reads per clock, read data registered) holds the previous row; when
// pixel (x, y) is accepted the result for pixel (x, y-1) is produced from its
// right neighbor in that row and the new pixel below. Per channel the gradient
// |c - right| + |c - below| is compared with edge_threshold; above it the
// channel becomes min(gradient + boost_offset, 255). The right column passes
// through with written_o low, and frame_last_o marks the last result of a
// frame. Row zero only fills the buffer, so results lag one row and the last
// row of a frame yields none. Throughput is one pixel per clock while the
// output is not stalled; a request moves from the input registers and the
// buffer read, loaded at the accepting edge, through the sharpen logic into
// the result register. The buffer needs no clearing pass after reset. Width
// and height are clamped to [2, MaxWidth] and [2, 1024]; the user must write
// registers only while the block is idle, which the block does not enforce.
`include "gradient_threshold_sharpen_assert.svh"

module gradient_threshold_sharpen
  import gts_pkg::*;
#(
  parameter int MaxWidth = MAX_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // pixel in
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       red_in_i,
  input  logic [7:0]       green_in_i,
  input  logic [7:0]       blue_in_i,
  // result out
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             written_o,
  output logic             frame_last_o
);

  localparam int CntW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int DimW = (CntW + 1 > CFG_W) ? CntW + 1 : CFG_W;

  // configuration registers
  logic [10:0] frame_width_q;
  logic [10:0] frame_height_q;
  logic [8:0]  edge_threshold_q;
  logic [7:0]  boost_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= WIDTH_RST;
      frame_height_q   <= HEIGHT_RST;
      edge_threshold_q <= THRESHOLD_RST;
      boost_offset_q   <= BOOST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data_i;
        CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data_i;
        CFG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data_i[8:0];
        CFG_BOOST_OFFSET:   boost_offset_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective geometry, clamped
  logic [DimW-1:0]  width_ext, width_eff, width_last;
  logic [CFG_W-1:0] height_eff, height_last;

  always_comb begin
    width_ext = DimW'(frame_width_q);
    if (width_ext < DimW'(2)) begin
      width_eff = DimW'(2);
    end else if (width_ext > DimW'(MaxWidth)) begin
      width_eff = DimW'(MaxWidth);
    end else begin
      width_eff = width_ext;
    end
    width_last = width_eff - DimW'(1);

    if (frame_height_q < CFG_W'(2)) begin
      height_eff = CFG_W'(2);
    end else if (frame_height_q > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height_q;
    end
    height_last = height_eff - CFG_W'(1);
  end

  // handshake and pipeline control
  logic s1_valid_q, out_valid_q;
  s1_t  s1_q;
  logic out_adv, s1_adv, in_acc;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // raster position
  logic [CntW-1:0]  col_cnt_q, col_nx;
  logic [ROW_W-1:0] row_cnt_q;
  logic             last_col, last_row, has_result;

  assign last_col   = DimW'(col_cnt_q) >= width_last;
  assign last_row   = CFG_W'(row_cnt_q) >= height_last;
  assign has_result = row_cnt_q != '0;
  assign col_nx     = (col_cnt_q == CntW'(MaxWidth - 1)) ? '0 : col_cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_cnt_q <= '0;
        row_cnt_q <= last_row ? '0 : row_cnt_q + ROW_W'(1);
      end else begin
        col_cnt_q <= col_nx;
      end
    end
  end

  // line buffer: reads see the previous row, the write replaces it
  pix_t line_mem [MaxWidth];
  pix_t above_q, right_q;
  pix_t pix_in;

  assign pix_in = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_q           <= line_mem[col_cnt_q];
      right_q           <= line_mem[col_nx];
      line_mem[col_cnt_q] <= pix_in;
    end
  end

  // stage 1: position info and pixel below, aligned with the buffer read
  logic s1_last_col_q, s1_frame_last_q;
  pix_t below_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= has_result;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      below_q         <= pix_in;
      s1_last_col_q   <= last_col;
      s1_frame_last_q <= last_col && last_row;
    end
  end

  always_comb begin
    s1_q.above      = above_q;
    s1_q.right      = right_q;
    s1_q.below      = below_q;
    s1_q.last_col   = s1_last_col_q;
    s1_q.frame_last = s1_frame_last_q;
  end

  // sharpen
  pix_t res_d;
  logic written_d;

  always_comb begin
    if (s1_q.last_col) begin
      res_d     = s1_q.above;
      written_d = 1'b0;
    end else begin
      res_d.red   = sharpen_chan(s1_q.above.red, s1_q.right.red, s1_q.below.red,
                                 edge_threshold_q, boost_offset_q);
      res_d.green = sharpen_chan(s1_q.above.green, s1_q.right.green, s1_q.below.green,
                                 edge_threshold_q, boost_offset_q);
      res_d.blue  = sharpen_chan(s1_q.above.blue, s1_q.right.blue, s1_q.below.blue,
                                 edge_threshold_q, boost_offset_q);
      written_d   = 1'b1;
    end
  end

  // result register
  pix_t res_q;
  logic written_q, frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q        <= res_d;
      written_q    <= written_d;
      frame_last_q <= s1_q.frame_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = res_q.red;
  assign green_out_o  = res_q.green;
  assign blue_out_o   = res_q.blue;
  assign written_o    = written_q;
  assign frame_last_o = frame_last_q;

  // checks
  `GTS_ASSERT_NEXT(a_row0_no_result, clk_i, rst_ni, in_acc && (row_cnt_q == '0),
                   !s1_valid_q, "row zero request produced a result")
  `GTS_ASSERT_NEXT(a_col_wrap, clk_i, rst_ni, in_acc && last_col,
                   col_cnt_q == '0, "column counter did not wrap at last column")
  `GTS_ASSERT_NOW(a_last_is_passthru, clk_i, rst_ni, out_valid_o && frame_last_o,
                  !written_o, "frame_last on a sharpened result")
  `GTS_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !s1_valid_q,
                  in_ready_o, "input stalled with empty stage 1")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Gradient sharpener testbench. Pixels stream in raster order over the
// valid/ready input channel; every accepted request is run through a local
// model of the line buffer and the sharpen rule, and the result it predicts,
// if any, is queued. Results are popped and compared field by field.
module tb;
  import gts_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall for back-pressure
  localparam int SETTLE_CYCLES   = 10;   // pipeline is two deep; margin on top
  localparam int STUCK_LIMIT     = 2000; // cycles with no handshake at all
  localparam int RAND_PHASES     = 16;
  localparam int PRESSURE_PHASE  = 4;    // a phase with no idling on either side

  // {pixel, written, frame_last} as it leaves the block
  typedef struct packed {
    pix_t px;
    logic written;
    logic last;
  } sharp_res_t;

  // One row of the directed table: a register write or a pixel request.
  // Where typed is set, want is queued instead of the model's answer.
  typedef struct packed {
    bit          cfg;
    cfg_idx_e    idx;
    logic [10:0] val;
    pix_t        px;
    bit          typed;
    sharp_res_t  want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       red_in_i;
  logic [7:0]       green_in_i;
  logic [7:0]       blue_in_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [7:0]       red_out_o;
  logic [7:0]       green_out_o;
  logic [7:0]       blue_out_o;
  logic             written_o;
  logic             frame_last_o;

  gradient_threshold_sharpen i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .written_o   (written_o),
    .frame_last_o(frame_last_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Local model: register copies, previous-row store and raster counters.
  // ---------------------------------------------------------------------------
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [8:0]  thr_reg;
  logic [7:0]  boost_reg;
  pix_t        row_mem     [MAX_WIDTH];
  bit          row_mem_set [MAX_WIDTH];  // entry holds a real pixel
  int unsigned col_pos;
  int unsigned row_pos;

  sharp_res_t  sharpened_q [$];  // predicted results, oldest first
  int          n_bad;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          hold_left;
  bit          stall_req;
  int          stuck_cycles;
  pix_t        last_px;

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // |c - right| + |c - below|; strictly above threshold -> boosted, saturating
  function automatic logic [7:0] edge_boost(logic [7:0] c, logic [7:0] right,
                                            logic [7:0] below);
    int ci, ri, bi, grad, sum;
    ci   = int'(c);
    ri   = int'(right);
    bi   = int'(below);
    grad = (ci > ri ? ci - ri : ri - ci) + (ci > bi ? ci - bi : bi - ci);
    if (grad > int'(thr_reg)) begin
      sum = grad + int'(boost_reg);
      return (sum > 255) ? 8'd255 : sum[7:0];
    end
    return c;
  endfunction

  // Advance the model by one accepted pixel. Returns 1 when the pixel above
  // it in the previous row comes out.
  function automatic bit sharpen_pixel(input pix_t below, output sharp_res_t res);
    int unsigned w, h, col;
    bit          last_col, last_row, has_res;
    pix_t        above, right;
    w        = clamp_dim(width_reg, MAX_WIDTH);
    h        = clamp_dim(height_reg, MAX_HEIGHT);
    last_col = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    col      = col_pos % MAX_WIDTH;
    has_res  = (row_pos != 0);
    res      = '0;
    if (has_res) begin
      above = row_mem[col];
      if (last_col) begin
        // right column: no neighbor, passes unchanged
        res.px      = above;
        res.written = 1'b0;
      end else begin
        right           = row_mem[(col + 1) % MAX_WIDTH];
        res.px.red      = edge_boost(above.red, right.red, below.red);
        res.px.green    = edge_boost(above.green, right.green, below.green);
        res.px.blue     = edge_boost(above.blue, right.blue, below.blue);
        res.written     = 1'b1;
      end
      res.last = last_col && last_row;
    end
    row_mem[col]     = below;
    row_mem_set[col] = 1'b1;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return has_res;
  endfunction

  // A new width must not make the block read a store entry never written.
  // In row zero every column up to the new edge gets written before use.
  function automatic bit width_fits(logic [10:0] w);
    int unsigned top;
    int          i;
    top = clamp_dim(w, MAX_WIDTH) - 1;
    if (col_pos > top) top = col_pos;
    if (row_pos == 0) return 1'b1;
    for (i = 0; i <= int'(top); i++) begin
      if (!row_mem_set[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Mix of noise, hard black/white edges and smooth areas (gradients near
  // a typical threshold, so both kept and boosted channels show up).
  function automatic pix_t rand_pixel();
    pix_t p;
    case ($urandom_range(3))
      0: p = pix_t'(24'($urandom));
      1: begin
        p.red   = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        p.green = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        p.blue  = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      end
      default: begin
        p.red   = nudge(last_px.red);
        p.green = nudge(last_px.green);
        p.blue  = nudge(last_px.blue);
      end
    endcase
    last_px = p;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All are entered and left just after a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one pixel request; valid is left high so back-to-back requests
  // keep it up. The model steps at the edge where the request is taken.
  task automatic send_pixel(input pix_t px, input bit typed, input sharp_res_t want);
    sharp_res_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    red_in_i   = px.red;
    green_in_i = px.green;
    blue_in_i  = px.blue;
    do @(posedge clk_i); while (!in_ready_o);
    if (sharpen_pixel(px, res) && !typed) sharpened_q.push_back(res);
    if (typed) sharpened_q.push_back(want);
    @(negedge clk_i);
  endtask

  // Wait until every predicted result is out, plus the pipeline depth, since
  // row-zero pixels may still be in flight without a result of their own.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sharpened_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [10:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CFG_FRAME_WIDTH:    width_reg  = val;
      CFG_FRAME_HEIGHT:   height_reg = val;
      CFG_EDGE_THRESHOLD: thr_reg    = val[8:0];
      CFG_BOOST_OFFSET:   boost_reg  = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Run out the current frame so the next settings start on row zero.
  task automatic run_to_frame_start();
    while (row_pos != 0 || col_pos != 0) send_pixel(rand_pixel(), 1'b0, '0);
    drain();
  endtask

  // New random settings; called with the block idle. Mostly small frames;
  // out-of-range sizes exercise the clamps. Some phases start mid-frame.
  task automatic new_setup(input bit from_top);
    logic [10:0] w, h;
    case ($urandom_range(7))
      0:       h = 11'($urandom_range(1));
      1:       h = 11'($urandom_range(1025, 2047));
      default: h = 11'($urandom_range(2, 7));
    endcase
    write_reg(CFG_FRAME_HEIGHT, h);
    if (from_top && clamp_dim(h, MAX_HEIGHT) <= 8) run_to_frame_start();
    case ($urandom_range(7))
      0:       w = 11'($urandom_range(1));
      default: w = 11'($urandom_range(2, 12));
    endcase
    if (width_fits(w)) write_reg(CFG_FRAME_WIDTH, w);
    // upper data bits beyond the register width are don't-care
    case ($urandom_range(7))
      0:       write_reg(CFG_EDGE_THRESHOLD, {2'($urandom_range(3)), 9'd0});
      1:       write_reg(CFG_EDGE_THRESHOLD, 11'd510);
      2:       write_reg(CFG_EDGE_THRESHOLD, 11'd511);
      3:       write_reg(CFG_EDGE_THRESHOLD, 11'($urandom_range(2047)));
      default: write_reg(CFG_EDGE_THRESHOLD, 11'($urandom_range(80)));
    endcase
    case ($urandom_range(3))
      0:       write_reg(CFG_BOOST_OFFSET, 11'd0);
      1:       write_reg(CFG_BOOST_OFFSET, 11'd255);
      default: write_reg(CFG_BOOST_OFFSET, 11'($urandom_range(2047)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. First frame runs 3x3 on the reset threshold (40) and
  // boost (100); row zero only fills the store. Then a 2x2 frame (width and
  // height below range, so clamped) with a threshold above any gradient, and
  // one with threshold zero and full boost.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [24] = '{
    '{1'b1, CFG_FRAME_WIDTH,    11'd3,   24'h000000, 1'b0, '0},
    '{1'b1, CFG_FRAME_HEIGHT,   11'd3,   24'h000000, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h000000, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h646464, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h648264, 1'b0, '0},
    // all channels over threshold, green saturates
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h00FF00, 1'b1, {24'hC8FFC8, 2'b10}},
    // gradients 20 and 40 kept, 41 boosted: threshold is strict
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h786E8D, 1'b1, {24'h64648D, 2'b10}},
    // right column passes through
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'hFF00FF, 1'b1, {24'h648264, 2'b00}},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h000000, 1'b1, {24'hDCFFF1, 2'b10}},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h010203, 1'b0, '0},
    // last result of the frame
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h090909, 1'b1, {24'hFF00FF, 2'b01}},
    '{1'b1, CFG_FRAME_WIDTH,    11'd0,   24'h000000, 1'b0, '0},
    '{1'b1, CFG_FRAME_HEIGHT,   11'd1,   24'h000000, 1'b0, '0},
    '{1'b1, CFG_EDGE_THRESHOLD, 11'd511, 24'h000000, 1'b0, '0},
    '{1'b1, CFG_BOOST_OFFSET,   11'd255, 24'h000000, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h00FF00, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'hFF00FF, 1'b0, '0},
    // largest gradient (510) still not above 511
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'hFF00FF, 1'b1, {24'h00FF00, 2'b10}},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h000000, 1'b1, {24'hFF00FF, 2'b01}},
    '{1'b1, CFG_EDGE_THRESHOLD, 11'd0,   24'h000000, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h323232, 1'b0, '0},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h323232, 1'b0, '0},
    // zero gradient kept, gradient one boosted to full scale
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h323332, 1'b1, {24'h32FF32, 2'b10}},
    '{1'b0, CFG_FRAME_WIDTH,    11'd0,   24'h000000, 1'b1, {24'h323232, 2'b01}}
  };

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_req) begin
      hold_left = HOLD_OFF_CYCLES;
      stall_req = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Result checker: oldest prediction against each accepted result.
  always @(posedge clk_i) begin
    sharp_res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {red_out_o, green_out_o, blue_out_o, written_o, frame_last_o};
      if (sharpened_q.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result r=%0d g=%0d b=%0d written=%0b last=%0b",
                   got.px.red, got.px.green, got.px.blue, got.written, got.last);
        n_bad++;
      end else begin
        want = sharpened_q.pop_front();
        if (got !== want) begin
          if (n_bad < 10)
            $display("mismatch: got r=%0d g=%0d b=%0d written=%0b last=%0b, %s",
                     got.px.red, got.px.green, got.px.blue, got.written, got.last,
                     $sformatf("want r=%0d g=%0d b=%0d written=%0b last=%0b",
                               want.px.red, want.px.green, want.px.blue,
                               want.written, want.last));
          n_bad++;
        end
      end
    end
  end

  // Watchdog: ends a run where no request moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int ph;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FRAME_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    red_in_i      = '0;
    green_in_i    = '0;
    blue_in_i     = '0;
    n_bad         = 0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_left     = 0;
    stall_req     = 1'b0;
    stuck_cycles  = 0;
    last_px       = '0;
    width_reg     = WIDTH_RST;
    height_reg    = HEIGHT_RST;
    thr_reg       = THRESHOLD_RST;
    boost_reg     = BOOST_RST;
    col_pos       = 0;
    row_pos       = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, cycling through the idling mixes.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0:       begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        1:       begin src_idle_pct = 71; sink_idle_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_idle_pct = 71; end
        default: begin src_idle_pct = 36; sink_idle_pct = 36; end
      endcase
      new_setup($urandom_range(1) != 0);
      // sender keeps offering through the hold-off, so the block backs up
      if (ph == PRESSURE_PHASE) stall_req = 1'b1;
      repeat ($urandom_range(30, 60)) send_pixel(rand_pixel(), 1'b0, '0);
    end

    // Widest line (width above range clamps to max): one full row, then the
    // start of the next one so the wrap and the first results are checked.
    drain();
    src_idle_pct  = 36;
    sink_idle_pct = 36;
    write_reg(CFG_FRAME_HEIGHT, 11'd2);
    run_to_frame_start();
    write_reg(CFG_FRAME_WIDTH, 11'h7FF);
    write_reg(CFG_EDGE_THRESHOLD, 11'($urandom_range(80)));
    repeat (MAX_WIDTH + 8) send_pixel(rand_pixel(), 1'b0, '0);

    drain();
    if (n_bad == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
